@@ src/swprs_pkg.sv @@
// shared types, codes and sizes for the stop-and-wait partial reliability sender
package swprs_pkg;

    // outcome window length and derived widths
    localparam int WINDOW_LEN = 10;
    localparam int WPOS_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int ONES_W     = $clog2(WINDOW_LEN + 1);

    // fixed field widths
    localparam int MODE_W     = 2;
    localparam int THRESH_W   = 7;
    localparam int TICKS_W    = 16;
    localparam int NUM_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    // reset values of the configuration registers
    localparam logic [MODE_W-1:0]   MODE_RESET    = 2'd2;
    localparam logic [THRESH_W-1:0] THRESH_RESET  = 7'd9;
    localparam logic [TICKS_W-1:0]  TIMEOUT_RESET = 16'd1000;

    // reliability modes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;

    // request kinds
    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_PDU  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    // emitted pdu kinds
    localparam logic [1:0] EMIT_NONE = 2'd0;
    localparam logic [1:0] EMIT_DATA = 2'd1;
    localparam logic [1:0] EMIT_ACK  = 2'd2;

    // outcome codes
    localparam logic [1:0] OC_NONE      = 2'd0;
    localparam logic [1:0] OC_DELIVERED = 2'd1;
    localparam logic [1:0] OC_LOSS      = 2'd2;
    localparam logic [1:0] OC_BUSY_ERR  = 2'd3;

    localparam logic [TICKS_W-1:0] TICK_MAX = {TICKS_W{1'b1}};

    typedef struct packed {
        logic [1:0]       action;
        logic             rx_ack_flag;
        logic             rx_syn_flag;
        logic [NUM_W-1:0] rx_ack_number;
        logic [NUM_W-1:0] rx_seq_number;
    } item_t;

    typedef struct packed {
        logic [1:0]       emit_kind;
        logic             emit_seq_bit;
        logic [NUM_W-1:0] emit_ack_number;
        logic             done_res;
        logic [1:0]       outcome;
    } result_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [THRESH_W-1:0] threshold;
        logic [TICKS_W-1:0]  timeout;
    } cfg_t;

    // request to record one outcome in the window
    typedef struct packed {
        logic rec;
        logic success;
    } win_req_t;

endpackage

@@ src/swprs_window.sv @@
// circular outcome window with success count and loss acceptance compare
module swprs_window
    import swprs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  win_req_t            win_req,
    input  logic [THRESH_W-1:0] threshold,
    output logic                loss_ok
);

    logic [WINDOW_LEN-1:0] window_reg, window_next;
    logic [WPOS_W-1:0]     pos_reg, pos_next;
    logic [ONES_W-1:0]     ones;

    always_comb begin
        ones = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            ones = ones + ONES_W'(window_reg[i]);
        end
    end

    assign loss_ok = (THRESH_W'(ones) >= threshold);

    always_comb begin
        window_next = window_reg;
        pos_next    = pos_reg;
        if (win_req.rec) begin
            window_next[pos_reg] = win_req.success;
            if (pos_reg == WPOS_W'(WINDOW_LEN - 1)) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            pos_reg    <= '0;
        end else begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

@@ src/swprs_ctrl.sv @@
// sender state, timeout counter and per-request decision logic
module swprs_ctrl
    import swprs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     fire,
    input  item_t    item,
    input  cfg_t     cfg,
    input  logic     loss_ok,
    output win_req_t win_req,
    output logic     res_valid,
    output result_t  res
);

    logic               busy_reg, busy_next;
    logic               seq_reg, seq_next;
    logic [TICKS_W-1:0] tick_reg, tick_next;
    logic [TICKS_W-1:0] limit;
    logic [TICKS_W-1:0] tick_inc;
    logic               partial;
    logic               ack_match;

    assign partial   = (cfg.mode != MODE_NONE) && (cfg.mode != MODE_FULL);
    assign limit     = (cfg.timeout == '0) ? TICKS_W'(1) : cfg.timeout;
    assign tick_inc  = (tick_reg < TICK_MAX) ? tick_reg + 1'b1 : tick_reg;
    assign ack_match = item.rx_ack_flag && (item.rx_ack_number == NUM_W'(seq_reg));

    always_comb begin
        busy_next   = busy_reg;
        seq_next    = seq_reg;
        tick_next   = tick_reg;
        win_req     = '0;
        res_valid   = 1'b0;
        res         = '0;
        unique case (item.action)
            ACT_SEND: begin
                res_valid = 1'b1;
                if (busy_reg) begin
                    res.outcome = OC_BUSY_ERR;
                end else begin
                    res.emit_kind    = EMIT_DATA;
                    res.emit_seq_bit = seq_reg;
                    if (cfg.mode == MODE_NONE) begin
                        res.done_res = 1'b1;
                        res.outcome  = OC_DELIVERED;
                    end else begin
                        busy_next = 1'b1;
                        tick_next = '0;
                    end
                end
            end
            ACT_PDU: begin
                if (busy_reg) begin
                    tick_next = '0;
                    if (ack_match) begin
                        seq_next        = ~seq_reg;
                        busy_next       = 1'b0;
                        win_req.rec     = partial;
                        win_req.success = 1'b1;
                        res_valid       = 1'b1;
                        res.done_res    = 1'b1;
                        res.outcome     = OC_DELIVERED;
                    end else if (item.rx_ack_flag && item.rx_syn_flag) begin
                        res_valid           = 1'b1;
                        res.emit_kind       = EMIT_ACK;
                        res.emit_ack_number = item.rx_seq_number;
                    end
                end
            end
            ACT_TICK: begin
                if (busy_reg) begin
                    tick_next = tick_inc;
                    if (tick_inc >= limit) begin
                        tick_next = '0;
                        res_valid = 1'b1;
                        if (partial && loss_ok) begin
                            win_req.rec     = 1'b1;
                            win_req.success = 1'b0;
                            busy_next       = 1'b0;
                            res.done_res    = 1'b1;
                            res.outcome     = OC_LOSS;
                        end else begin
                            res.emit_kind    = EMIT_DATA;
                            res.emit_seq_bit = seq_reg;
                        end
                    end
                end
            end
            default: begin
                // unused request code, ignored
            end
        endcase
        if (!fire) begin
            busy_next = busy_reg;
            seq_next  = seq_reg;
            tick_next = tick_reg;
            win_req   = '0;
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            seq_reg  <= 1'b0;
            tick_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            seq_reg  <= seq_next;
            tick_reg <= tick_next;
        end
    end

endmodule

@@ src/stop_wait_partial_reliability_sender.sv @@
// top level: input register, configuration registers, control and result register
//
// sender side of an alternating-bit stop-and-wait link with partial reliability
// input channel (s_valid/s_ready): one request per beat - a send request, a
//   received pdu header or a timer tick, selected by s_action
// result channel (m_valid/m_ready): zero or one result per request, carrying
//   the pdu to emit, the done flag and the outcome of the pending send
// configuration: cfg_we writes cfg_data into register cfg_index
//   (0 reliability mode, 1 accept threshold, 2 timeout ticks); write only
//   while no request is in flight
// latency: two cycles from request to result, one in the input register,
//   one through the decision logic into the result register
// throughput: one request per cycle, set by the single decision stage that
//   reads and updates the sender state for each request
// reset (aresetn low, synchronous): idle, sequence bit 0, window cleared,
//   configuration back to mode 2, threshold 9, timeout 1000
// receiver stall: a held result keeps the input register full, s_ready
//   then drops until the result is taken
module stop_wait_partial_reliability_sender
    import swprs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic                  s_rx_ack_flag,
    input  logic                  s_rx_syn_flag,
    input  logic [NUM_W-1:0]      s_rx_ack_number,
    input  logic [NUM_W-1:0]      s_rx_seq_number,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_emit_kind,
    output logic                  m_emit_seq_bit,
    output logic [NUM_W-1:0]      m_emit_ack_number,
    output logic                  m_done_res,
    output logic [1:0]            m_outcome
);

    cfg_t     cfg_reg, cfg_next;
    logic     in_valid_reg, in_valid_next;
    item_t    in_item_reg, in_item_next;
    logic     out_valid_reg, out_valid_next;
    result_t  out_res_reg, out_res_next;
    logic     advance;
    logic     loss_ok;
    win_req_t win_req;
    logic     res_valid;
    result_t  res;

    // configuration registers, upper data bits dropped per register width
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_MODE:    cfg_next.mode      = cfg_data[MODE_W-1:0];
                CFG_THRESH:  cfg_next.threshold = cfg_data[THRESH_W-1:0];
                CFG_TIMEOUT: cfg_next.timeout   = cfg_data[TICKS_W-1:0];
                default: begin
                    // no register at this index
                end
            endcase
        end
    end

    // the held request goes through once the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_valid && s_ready) begin
            in_valid_next              = 1'b1;
            in_item_next.action        = s_action;
            in_item_next.rx_ack_flag   = s_rx_ack_flag;
            in_item_next.rx_syn_flag   = s_rx_syn_flag;
            in_item_next.rx_ack_number = s_rx_ack_number;
            in_item_next.rx_seq_number = s_rx_seq_number;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // result register; requests with no result leave it untouched
    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance && res_valid) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    swprs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .loss_ok   (loss_ok),
        .win_req   (win_req),
        .res_valid (res_valid),
        .res       (res)
    );

    swprs_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .win_req   (win_req),
        .threshold (cfg_reg.threshold),
        .loss_ok   (loss_ok)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode      <= MODE_RESET;
            cfg_reg.threshold <= THRESH_RESET;
            cfg_reg.timeout   <= TIMEOUT_RESET;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_emit_kind       = out_res_reg.emit_kind;
    assign m_emit_seq_bit    = out_res_reg.emit_seq_bit;
    assign m_emit_ack_number = out_res_reg.emit_ack_number;
    assign m_done_res        = out_res_reg.done_res;
    assign m_outcome         = out_res_reg.outcome;

endmodule
